// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Decoder modes.
    typedef enum logic [2:0] {
        M_TEXT,
        M_ESC,
        M_HEX_HI,
        M_WANT_BS,
        M_WANT_U,
        M_HEX_LO
    } mode_t;

    // Status codes reported with the final result of a body.
    typedef enum logic [2:0] {
        E_OK       = 3'd0,
        E_DANGLING = 3'd1,
        E_SHORT_U  = 3'd2,
        E_BAD_HEX  = 3'd3,
        E_LONE_HI  = 3'd4,
        E_BAD_LOW  = 3'd5,
        E_LONE_LO  = 3'd6,
        E_BAD_ESC  = 3'd7
    } status_t;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_B         = 8'h62;
    localparam logic [7:0] CH_F         = 8'h66;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_U         = 8'h75;

    // Top six bits of a high and of a low surrogate code unit.
    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // One input transaction.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_only;
        logic       is_last;
    } in_item_t;

    // One output transaction.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_body;
        logic [2:0] status;
    } out_item_t;

    // All results caused by one input item.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      cnt_m1;
        logic            has_bytes;
        logic            end_flag;
        status_t         status;
    } bundle_t;

endpackage

// ===== rtl/jsu_stream_if.sv =====
// ----------------------------------------------------------------------------
// jsu_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface jsu_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/jsu_decode.sv =====
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state and single-pass decode of one input byte.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  jsu_pkg::in_item_t item,
    output logic              push,
    output jsu_pkg::bundle_t  bundle
);
    import jsu_pkg::*;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      n;
    } utf8_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r.bytes = '0;
        if (cp[20:7] == 14'd0) begin
            r.n        = 3'd1;
            r.bytes[0] = {1'b0, cp[6:0]};
        end
        else if (cp[20:11] == 10'd0) begin
            r.n        = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end
        else if (cp[20:16] == 5'd0) begin
            r.n        = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end
        else begin
            r.n        = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

    function automatic hex_t hex_value(input logic [7:0] b);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r.val = 4'(b - 8'h30);
        end
        else if (b >= 8'h61 && b <= 8'h66) begin
            r.val = 4'(b - 8'h57);
        end
        else if (b >= 8'h41 && b <= 8'h46) begin
            r.val = 4'(b - 8'h37);
        end
        else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    mode_t       mode_reg, mode_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [15:0] cu_reg, cu_next;
    logic [9:0]  hi_reg, hi_next;
    logic        bad_reg, bad_next;
    status_t     err_reg, err_next;

    hex_t        hv;
    logic [15:0] cu_shift;
    logic        bad_shift;
    utf8_t       enc;
    logic        last;
    status_t     final_status;

    always_comb
    begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        cu_next   = cu_reg;
        hi_next   = hi_reg;
        bad_next  = bad_reg;
        err_next  = err_reg;
        enc       = '0;
        hv        = hex_value(item.in_byte);
        cu_shift  = {cu_reg[11:0], hv.ok ? hv.val : 4'd0};
        bad_shift = bad_reg | ~hv.ok;
        last      = item.end_only | item.is_last;

        if (!item.end_only && err_reg == E_OK) begin
            unique case (mode_reg)
                M_TEXT:
                begin
                    if (item.in_byte == CH_BACKSLASH) begin
                        mode_next = M_ESC;
                    end
                    else begin
                        enc.n        = 3'd1;
                        enc.bytes[0] = item.in_byte;
                    end
                end
                M_ESC:
                begin
                    mode_next    = M_TEXT;
                    enc.n        = 3'd1;
                    case (item.in_byte)
                        CH_QUOTE:     enc.bytes[0] = CH_QUOTE;
                        CH_BACKSLASH: enc.bytes[0] = CH_BACKSLASH;
                        CH_SLASH:     enc.bytes[0] = CH_SLASH;
                        CH_B:         enc.bytes[0] = 8'h08;
                        CH_F:         enc.bytes[0] = 8'h0C;
                        CH_N:         enc.bytes[0] = 8'h0A;
                        CH_R:         enc.bytes[0] = 8'h0D;
                        CH_T:         enc.bytes[0] = 8'h09;
                        CH_U:
                        begin
                            enc.n     = 3'd0;
                            mode_next = M_HEX_HI;
                            cnt_next  = 2'd0;
                            cu_next   = 16'd0;
                            bad_next  = 1'b0;
                        end
                        default:
                        begin
                            enc.n    = 3'd0;
                            err_next = E_BAD_ESC;
                        end
                    endcase
                end
                M_HEX_HI, M_HEX_LO:
                begin
                    cu_next  = cu_shift;
                    bad_next = bad_shift;
                    cnt_next = cnt_reg + 2'd1;
                    // The fourth hex position completes the code unit.
                    if (cnt_reg == 2'd3) begin
                        if (bad_shift) begin
                            err_next = E_BAD_HEX;
                        end
                        else if (mode_reg == M_HEX_HI) begin
                            if (cu_shift[15:10] == HI_SURR_TAG) begin
                                hi_next   = cu_shift[9:0];
                                mode_next = M_WANT_BS;
                            end
                            else if (cu_shift[15:10] == LO_SURR_TAG) begin
                                err_next = E_LONE_LO;
                            end
                            else begin
                                enc       = utf8_encode({5'd0, cu_shift});
                                mode_next = M_TEXT;
                            end
                        end
                        else if (cu_shift[15:10] != LO_SURR_TAG) begin
                            err_next = E_BAD_LOW;
                        end
                        else begin
                            // 0x10000 + (high << 10) + low bits.
                            enc = utf8_encode({11'(hi_reg) + 11'd64, cu_shift[9:0]});
                            mode_next = M_TEXT;
                        end
                    end
                end
                M_WANT_BS:
                begin
                    if (item.in_byte == CH_BACKSLASH) begin
                        mode_next = M_WANT_U;
                    end
                    else begin
                        err_next = E_LONE_HI;
                    end
                end
                M_WANT_U:
                begin
                    if (item.in_byte == CH_U) begin
                        mode_next = M_HEX_LO;
                        cnt_next  = 2'd0;
                        cu_next   = 16'd0;
                        bad_next  = 1'b0;
                    end
                    else begin
                        err_next = E_LONE_HI;
                    end
                end
                default:
                begin
                    mode_next = M_TEXT;
                end
            endcase
        end

        // A body that ends mid-escape reports the kind of escape left open.
        if (err_next != E_OK) begin
            final_status = err_next;
        end
        else begin
            case (mode_next)
                M_ESC:                        final_status = E_DANGLING;
                M_HEX_HI:                     final_status = E_SHORT_U;
                M_WANT_BS, M_WANT_U, M_HEX_LO: final_status = E_LONE_HI;
                default:                      final_status = E_OK;
            endcase
        end

        if (last) begin
            mode_next = M_TEXT;
            cnt_next  = 2'd0;
            cu_next   = 16'd0;
            hi_next   = 10'd0;
            bad_next  = 1'b0;
            err_next  = E_OK;
        end

        bundle.bytes     = enc.bytes;
        bundle.has_bytes = (enc.n != 3'd0);
        bundle.cnt_m1    = bundle.has_bytes ? 2'(enc.n - 3'd1) : 2'd0;
        bundle.end_flag  = last;
        bundle.status    = last ? final_status : E_OK;
        push             = take & (bundle.has_bytes | last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_TEXT;
            cnt_reg  <= 2'd0;
            cu_reg   <= 16'd0;
            hi_reg   <= 10'd0;
            bad_reg  <= 1'b0;
            err_reg  <= E_OK;
        end
        else if (take) begin
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
            cu_reg   <= cu_next;
            hi_reg   <= hi_next;
            bad_reg  <= bad_next;
            err_reg  <= err_next;
        end
    end

endmodule

// ===== rtl/jsu_result_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_result_queue
// Two-entry queue of result groups, sent out one byte per transaction.
// ----------------------------------------------------------------------------
module jsu_result_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  jsu_pkg::bundle_t   bundle,
    output logic               can_push,
    output logic               out_valid,
    input  logic               out_ready,
    output jsu_pkg::out_item_t out_item
);
    import jsu_pkg::*;

    bundle_t    slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] idx_reg, idx_next;

    bundle_t    head;
    logic       at_tail;
    logic       pop;

    always_comb
    begin
        head      = slot_reg[rd_ptr_reg];
        at_tail   = (idx_reg == head.cnt_m1);
        out_valid = (count_reg != 2'd0);
        can_push  = (count_reg != 2'd2);
        pop       = out_valid & out_ready & at_tail;

        out_item.out_byte    = head.bytes[idx_reg];
        out_item.byte_valid  = head.has_bytes;
        out_item.end_of_body = head.end_flag & at_tail;
        out_item.status      = (head.end_flag & at_tail) ? head.status : E_OK;

        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;

        idx_next = idx_reg;
        if (out_valid && out_ready) begin
            idx_next = at_tail ? 2'd0 : idx_reg + 2'd1;
        end

        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            idx_reg    <= 2'd0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= bundle;
        end
    end

endmodule

// ===== rtl/json_string_unescaper.sv =====
// Each result is registered in the result queue before it is sent out.
// Throughput: one input byte per cycle while the result queue has room; an
// item that decodes to N bytes (N up to 4, from a completed \u escape) is
// sent out as N output transactions, and a full two-entry queue stalls input.
// Reset: asynchronous, active low; the decoder returns to plain text mode
// with no error latched and the result queue is emptied.
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes the escapes of a JSON string body into raw bytes and UTF-8.
// ----------------------------------------------------------------------------
module json_string_unescaper (
    input  logic         clk,
    input  logic         rst_n,
    jsu_stream_if.sink   byte_stream,
    jsu_stream_if.source result_stream
);
    import jsu_pkg::*;

    // Each accepted input transaction is decoded in a single pass against the
    // decoder state. All results it causes (zero to four bytes, plus an empty
    // closing result when the body ends without a byte) form one group that
    // is written into a two-entry queue. The queue hands out one output
    // transaction per ready cycle, marking the last result of a body with
    // end_of_body and the status. With two entries, a new input transaction
    // is taken while a finished group still waits for the consumer.

    in_item_t  item;
    logic      take;
    logic      push;
    logic      can_push;
    bundle_t   bundle;
    out_item_t out_item;

    assign item              = byte_stream.payload;
    assign byte_stream.ready = can_push;
    assign take              = byte_stream.valid & can_push;

    jsu_decode u_decode (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .push   (push),
        .bundle (bundle)
    );

    jsu_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .bundle    (bundle),
        .can_push  (can_push),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .out_item  (out_item)
    );

    assign result_stream.payload = out_item;

endmodule
